### design/assert_macros.svh
// ------------------------------------------------------------------------
// assertion macros
// clocked property checks used by the allocator unit
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every rising clk edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/fisa_pkg.sv
// ------------------------------------------------------------------------
// fisa_pkg
// shared types and constants of the free id stack allocator
// ------------------------------------------------------------------------
package fisa_pkg;

  localparam int ID_W     = 9;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_OUT  = 2'd3;

  localparam logic [ID_W-1:0] POOL_RESET = 9'd256;

  // shift command broadcast to every cell of the chain
  typedef struct packed {
    logic pop;   // every cell takes its lower neighbor
    logic push;  // every cell takes its upper neighbor
  } fisa_shift_t;

endpackage

### design/fisa_cell.sv
// ------------------------------------------------------------------------
// fisa_cell
// one slot of the free stack; shifts toward or away from the top
// ------------------------------------------------------------------------
module fisa_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  fisa_pkg::fisa_shift_t        shift,
  input  logic [fisa_pkg::ID_W-1:0]    from_above,
  input  logic [fisa_pkg::ID_W-1:0]    from_below,
  output logic [fisa_pkg::ID_W-1:0]    slot
);
  import fisa_pkg::*;

  logic [ID_W-1:0] slot_next;

  always_comb begin
    slot_next = slot;
    if (shift.pop) begin
      slot_next = from_below;
    end else if (shift.push) begin
      slot_next = from_above;
    end
  end

  // zero marks a slot never filled
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule

### design/free_id_stack_allocator_unit.sv
// ------------------------------------------------------------------------
// free_id_stack_allocator_unit
// hands out ids 1..pool_size (clamped to MAX_IDS) from a stack of free slots and takes them back
// ------------------------------------------------------------------------
// channel   dir  tdata                     tuser
// s_axis    in   [8:0] id_in, pad to 16    [0] cmd (0 get, 1 put)
// m_axis    out  [8:0] id_out, pad to 16   [1:0] status
// cfg       in   cfg_data[8:0] pool_size   (written when cfg_we is high)
//
// one command per cycle while s_axis_tready is high: each transfer is decided and
// the chain shifted at the accepting edge, and the result is captured in the output
// register at that same edge; the chain shift is the single step per command
// s_axis_tready stays high while the output register is empty or drained
// rst (synchronous) clears the chain, the top pointer and the output valid
// ------------------------------------------------------------------------
module free_id_stack_allocator_unit #(
  parameter int MAX_IDS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // [8:0] id_in
  input  logic                            s_axis_tuser,   // [0] cmd
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // [8:0] id_out
  output logic [fisa_pkg::STATUS_W-1:0]   m_axis_tuser,   // [1:0] status
  input  logic                            cfg_we,
  input  logic [fisa_pkg::ID_W-1:0]       cfg_data
);
  import fisa_pkg::*;

`include "assert_macros.svh"

  localparam int PTR_W = $clog2(MAX_IDS + 1);
  // compare width covering the pointer and the 9-bit fields
  localparam int CW    = (PTR_W > ID_W + 1) ? PTR_W : ID_W + 1;

  logic [ID_W-1:0]  pool_size;
  logic [PTR_W-1:0] top_ptr;
  logic [PTR_W-1:0] top_ptr_next;
  logic [ID_W-1:0]  slot_val [MAX_IDS];

  logic [ID_W-1:0]     id_out;
  logic [STATUS_W-1:0] status;

  logic              accept;
  logic              cmd;
  logic [ID_W-1:0]   id_in;
  logic [CW-1:0]     top_ext;
  logic [CW-1:0]     pool_ext;
  logic [CW-1:0]     id_ext;
  logic [CW-1:0]     max_ext;
  logic              exhausted;
  logic              invalid;
  logic              get_ok;
  logic [ID_W-1:0]   head_id;
  logic [ID_W-1:0]   res_id;
  logic [STATUS_W-1:0] res_status;
  fisa_shift_t       shift;

  assign cmd    = s_axis_tuser;
  assign id_in  = s_axis_tdata[ID_W-1:0];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;

  // limits: the pool is clamped to the number of cells
  assign top_ext  = CW'(top_ptr);
  assign pool_ext = CW'(pool_size);
  assign id_ext   = CW'(id_in);
  assign max_ext  = CW'(MAX_IDS);
  assign exhausted = (top_ext >= pool_ext) || (top_ext >= max_ext);
  assign invalid   = (id_in == '0) || (id_ext > pool_ext) || (id_ext > max_ext);

  // accepted get that pops a slot
  assign get_ok = accept && (cmd == CMD_GET) && !exhausted;

  // a never-filled head slot stands for its own position plus one
  assign head_id = (slot_val[0] == '0) ? ID_W'(top_ext + CW'(1)) : slot_val[0];

  always_comb begin
    shift        = '0;
    top_ptr_next = top_ptr;
    res_id       = '0;
    res_status   = ST_OK;
    if (cmd == CMD_GET) begin
      if (exhausted) begin
        res_status = ST_EXHAUSTED;
      end else begin
        res_id       = head_id;
        shift.pop    = accept;
        top_ptr_next = top_ptr + PTR_W'(1);
      end
    end else begin
      if (invalid) begin
        res_status = ST_INVALID;
      end else if (top_ptr == '0) begin
        res_status = ST_NONE_OUT;
      end else begin
        shift.push   = accept;
        top_ptr_next = top_ptr - PTR_W'(1);
      end
    end
  end

  // chain of slots: cell 0 is the slot at the top pointer
  genvar k;
  generate
    for (k = 0; k < MAX_IDS; k++) begin : g_cell
      logic [ID_W-1:0] above;
      logic [ID_W-1:0] below;
      if (k == 0) begin : g_first
        assign above = id_in;
      end else begin : g_mid_a
        assign above = slot_val[k-1];
      end
      if (k == MAX_IDS - 1) begin : g_last
        assign below = '0;
      end else begin : g_mid_b
        assign below = slot_val[k+1];
      end
      fisa_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (shift),
        .from_above (above),
        .from_below (below),
        .slot       (slot_val[k])
      );
    end
  endgenerate

  // pool size register and top pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= POOL_RESET;
      top_ptr   <= '0;
    end else begin
      if (cfg_we) begin
        pool_size <= cfg_data;
      end
      if (accept) begin
        top_ptr <= top_ptr_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_out <= res_id;
      status <= res_status;
    end
  end

  assign m_axis_tdata = {{(16 - ID_W){1'b0}}, id_out};
  assign m_axis_tuser = status;

  // checks
  `ASSERT_CLK(a_top_bound, top_ext <= max_ext, "top pointer beyond chain length")
  `ASSERT_CLK(a_get_adv, get_ok |=> top_ptr == $past(top_ptr) + PTR_W'(1), "top not advanced")
  `ASSERT_CLK(a_err_zero, m_axis_tvalid && status != ST_OK |-> id_out == '0, "error carries an id")
  `ASSERT_CLK(a_get_nonzero, get_ok |=> id_out != '0 || MAX_IDS > 511, "get handed out id zero")

endmodule
